/* design/pts_pkg.sv */
package pts_pkg;

	localparam int ID_W    = 4;
	localparam int PRIO_W  = 6;
	localparam int WAKE_W  = 64;
	localparam int SLICE_W = 8;
	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd4;
	localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'd255;

	typedef enum logic [2:0] {
		K_TICK    = 3'd0,
		K_CREATE  = 3'd1,
		K_UNBLOCK = 3'd2,
		K_YIELD   = 3'd3,
		K_BLOCK   = 3'd4,
		K_SLEEP   = 3'd5,
		K_SETPRIO = 3'd6,
		K_EXIT    = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_INVAL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WAKE,
		S_YIELD,
		S_YINS,
		S_DISP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} rdy_entry_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [WAKE_W-1:0] wake;
		logic [PRIO_W-1:0] prio;
	} slp_entry_t;

	// Shift command broadcast to every cell of one chain.
	typedef struct packed {
		logic ins;
		logic pop;
	} qop_t;

endpackage

/* design/pts_rdy_cell.sv */
module pts_rdy_cell import pts_pkg::*; (
	input  logic       clk,
	input  qop_t       op,
	input  logic       valid,
	input  rdy_entry_t new_entry,
	input  logic       left_ge,
	input  rdy_entry_t left_entry,
	input  rdy_entry_t right_entry,
	output logic       ge,
	output rdy_entry_t entry_q
);

	// An occupied cell whose priority is not below the newcomer stays put, so
	// equal priorities keep arrival order.
	assign ge = valid && (entry_q.prio >= new_entry.prio);

	always_ff @(posedge clk) begin
		if (op.pop) begin
			entry_q <= right_entry;
		end else if (op.ins && !ge) begin
			entry_q <= left_ge ? new_entry : left_entry;
		end
	end

endmodule

/* design/pts_slp_cell.sv */
module pts_slp_cell import pts_pkg::*; (
	input  logic       clk,
	input  qop_t       op,
	input  logic       valid,
	input  slp_entry_t new_entry,
	input  logic       left_ge,
	input  slp_entry_t left_entry,
	input  slp_entry_t right_entry,
	output logic       ge,
	output slp_entry_t entry_q
);

	// Earlier or equal wake ticks stay ahead of the newcomer.
	assign ge = valid && (entry_q.wake <= new_entry.wake);

	always_ff @(posedge clk) begin
		if (op.pop) begin
			entry_q <= right_entry;
		end else if (op.ins && !ge) begin
			entry_q <= left_ge ? new_entry : left_entry;
		end
	end

endmodule

/* design/priority_task_scheduler_with_sleep_queue.sv */
// Events are handled one at a time: a new event is taken only in the idle state, after the
// result of the last one has been loaded into the output register. A tick's wake pass moves
// one sleeper per cycle between the two cell chains.
// Reset (arst_n low, asynchronous): both queues empty, idle task running, time and slice
// counters zero, slice_length 4, no result pending.
module priority_task_scheduler_with_sleep_queue import pts_pkg::*; #(
	parameter int MAX_TASKS   = 16,
	parameter int PRIO_LEVELS = 64,
	localparam int IDW  = $clog2(MAX_TASKS + 1),
	localparam int CNTW = $clog2(MAX_TASKS + 1),
	localparam int OW   = IDW + PRIO_W + 1 + CNTW + 2,
	localparam int OTW  = ((OW + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [7:0]     cfg_data,       // slice_length
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [79:0]    s_axis_tdata,   // task_id[3:0], priority_req[9:4], wake_tick[72:10]
	input  logic [2:0]     s_axis_tuser,   // kind[2:0]
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [OTW-1:0] m_axis_tdata    // running_id, running_priority, switched,
	                                       // woken_count, status (lowest bit up)
);

	// The ready queue and the sleep queue are each a row of cells. An insert
	// moves every cell behind the insertion point one place back, all in the same cycle;
	// a pop moves every cell one place forward. Only cells below the fill
	// count hold meaningful data.

	localparam logic [IDW-1:0]  IDLE_ID = IDW'(MAX_TASKS);
	localparam logic [CNTW-1:0] FULL_CNT = CNTW'(MAX_TASKS);

	state_t state_q, state_d;

	logic [SLICE_W-1:0] slice_len_q, slice_q;
	logic [WAKE_W-1:0]  now_q;
	logic [CNTW-1:0]    rdy_cnt_q, slp_cnt_q, woken_q;
	logic [IDW-1:0]     cur_id_q, old_id_q;
	logic [PRIO_W-1:0]  cur_prio_q;
	status_t            status_q;
	kind_t              kind_q;
	logic [ID_W-1:0]    tid_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [62:0]        wake_q;
	rdy_entry_t         yield_q;
	logic               out_valid_q;
	logic [OTW-1:0]     out_data_q;

	// Chain wiring.
	qop_t       rdy_op, slp_op;
	rdy_entry_t rdy_new;
	slp_entry_t slp_new;
	rdy_entry_t rdy_q   [MAX_TASKS];
	slp_entry_t slp_q   [MAX_TASKS];
	logic       rdy_ge  [MAX_TASKS];
	logic       slp_ge  [MAX_TASKS];

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cells
		rdy_entry_t r_left, r_right;
		slp_entry_t s_left, s_right;
		logic       r_lge, s_lge;
		if (i == 0) begin : g_head
			assign r_left = rdy_new;
			assign s_left = slp_new;
			assign r_lge  = 1'b1;
			assign s_lge  = 1'b1;
		end else begin : g_body
			assign r_left = rdy_q[i-1];
			assign s_left = slp_q[i-1];
			assign r_lge  = rdy_ge[i-1];
			assign s_lge  = slp_ge[i-1];
		end
		if (i == MAX_TASKS - 1) begin : g_tail
			assign r_right = '0;
			assign s_right = '0;
		end else begin : g_mid
			assign r_right = rdy_q[i+1];
			assign s_right = slp_q[i+1];
		end

		pts_rdy_cell u_rdy (
			.clk         (clk),
			.op          (rdy_op),
			.valid       (CNTW'(i) < rdy_cnt_q),
			.new_entry   (rdy_new),
			.left_ge     (r_lge),
			.left_entry  (r_left),
			.right_entry (r_right),
			.ge          (rdy_ge[i]),
			.entry_q     (rdy_q[i])
		);

		pts_slp_cell u_slp (
			.clk         (clk),
			.op          (slp_op),
			.valid       (CNTW'(i) < slp_cnt_q),
			.new_entry   (slp_new),
			.left_ge     (s_lge),
			.left_entry  (s_left),
			.right_entry (s_right),
			.ge          (slp_ge[i]),
			.entry_q     (slp_q[i])
		);
	end

	// Shared conditions.
	logic               cur_idle, rdy_full, slp_full, rdy_any, wake_due, bad_tid;
	logic [SLICE_W-1:0] slice_len_eff, slice_inc;
	logic [PRIO_W-1:0]  prio_clamped;

	assign cur_idle      = (cur_id_q == IDLE_ID);
	assign rdy_full      = (rdy_cnt_q >= FULL_CNT);
	assign slp_full      = (slp_cnt_q >= FULL_CNT);
	assign rdy_any       = (rdy_cnt_q != '0);
	assign wake_due      = (slp_cnt_q != '0) && (slp_q[0].wake <= now_q);
	assign bad_tid       = (32'(tid_q) >= MAX_TASKS);
	assign slice_len_eff = (slice_len_q == '0) ? SLICE_W'(1) : slice_len_q;
	assign slice_inc     = (slice_q == SLICE_MAX) ? SLICE_MAX : slice_q + SLICE_W'(1);
	assign prio_clamped  = (32'(s_axis_tdata[9:4]) >= PRIO_LEVELS) ?
	                       PRIO_W'(PRIO_LEVELS - 1) : s_axis_tdata[9:4];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (kind_q)
					K_TICK: state_d = S_WAKE;
					K_CREATE, K_UNBLOCK: begin
						if (!bad_tid && !rdy_full && kind_q == K_CREATE && cur_prio_q < prio_q) begin
							state_d = S_YIELD;
						end else begin
							state_d = S_DONE;
						end
					end
					K_YIELD: state_d = S_YIELD;
					K_BLOCK, K_EXIT: state_d = cur_idle ? S_DONE : S_DISP;
					K_SLEEP: state_d = (cur_idle || slp_full) ? S_DONE : S_DISP;
					K_SETPRIO: begin
						if (!cur_idle && rdy_any && rdy_q[0].prio > prio_q) begin
							state_d = S_YIELD;
						end else begin
							state_d = S_DONE;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_WAKE: begin
				if (!wake_due) begin
					if (slice_inc >= slice_len_eff || (cur_idle && rdy_any)) begin
						state_d = S_YIELD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_YIELD: begin
				if (!cur_idle && rdy_any && rdy_q[0].prio >= cur_prio_q) begin
					state_d = S_YINS;
				end else begin
					state_d = S_DONE;
				end
			end
			S_YINS: state_d = S_DONE;
			S_DISP: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath controls.
	logic accept, now_inc, dispatch, save_yield, set_prio, slice_clr, slice_step;
	logic woken_inc, mark_full, mark_inval, out_load;

	always_comb begin
		rdy_op     = '0;
		slp_op     = '0;
		rdy_new    = '{id: tid_q, prio: prio_q};
		slp_new    = '{id: ID_W'(cur_id_q), wake: {1'b0, wake_q}, prio: cur_prio_q};
		accept     = 1'b0;
		now_inc    = 1'b0;
		dispatch   = 1'b0;
		save_yield = 1'b0;
		set_prio   = 1'b0;
		slice_clr  = 1'b0;
		slice_step = 1'b0;
		woken_inc  = 1'b0;
		mark_full  = 1'b0;
		mark_inval = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			S_IDLE: accept = s_axis_tvalid;
			S_EXEC: begin
				case (kind_q)
					K_TICK: now_inc = 1'b1;
					K_CREATE, K_UNBLOCK: begin
						if (bad_tid) begin
							mark_inval = 1'b1;
						end else if (rdy_full) begin
							mark_full = 1'b1;
						end else begin
							rdy_op.ins = 1'b1;
						end
					end
					K_BLOCK, K_EXIT: mark_inval = cur_idle;
					K_SLEEP: begin
						if (cur_idle) begin
							mark_inval = 1'b1;
						end else if (slp_full) begin
							mark_full = 1'b1;
						end else begin
							slp_op.ins = 1'b1;
						end
					end
					K_SETPRIO: begin
						mark_inval = cur_idle;
						set_prio   = !cur_idle;
					end
					default: ;
				endcase
			end
			S_WAKE: begin
				rdy_new = '{id: slp_q[0].id, prio: slp_q[0].prio};
				if (wake_due) begin
					slp_op.pop = 1'b1;
					if (rdy_full) begin
						mark_full = 1'b1;
					end else begin
						rdy_op.ins = 1'b1;
						woken_inc  = 1'b1;
					end
				end else begin
					slice_step = 1'b1;
				end
			end
			S_YIELD: begin
				if (cur_idle) begin
					dispatch = 1'b1;
				end else if (rdy_any && rdy_q[0].prio >= cur_prio_q) begin
					dispatch   = 1'b1;
					save_yield = 1'b1;
				end else begin
					slice_clr = 1'b1;
				end
			end
			S_YINS: begin
				rdy_new    = yield_q;
				rdy_op.ins = 1'b1;
			end
			S_DISP: dispatch = 1'b1;
			S_DONE: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
		if (dispatch) begin
			rdy_op.pop = rdy_any;
			slice_clr  = 1'b1;
		end
	end

	// Control and status registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slice_len_q <= SLICE_RESET;
			slice_q     <= '0;
			now_q       <= '0;
			rdy_cnt_q   <= '0;
			slp_cnt_q   <= '0;
			cur_id_q    <= IDLE_ID;
			cur_prio_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				slice_len_q <= cfg_data;
			end
			if (now_inc) begin
				now_q <= now_q + WAKE_W'(1);
			end
			if (slice_clr) begin
				slice_q <= '0;
			end else if (slice_step) begin
				slice_q <= slice_inc;
			end
			if (rdy_op.ins) begin
				rdy_cnt_q <= rdy_cnt_q + CNTW'(1);
			end else if (rdy_op.pop) begin
				rdy_cnt_q <= rdy_cnt_q - CNTW'(1);
			end
			if (slp_op.ins) begin
				slp_cnt_q <= slp_cnt_q + CNTW'(1);
			end else if (slp_op.pop) begin
				slp_cnt_q <= slp_cnt_q - CNTW'(1);
			end
			if (dispatch) begin
				if (rdy_any) begin
					cur_id_q   <= IDW'(rdy_q[0].id);
					cur_prio_q <= rdy_q[0].prio;
				end else begin
					cur_id_q   <= IDLE_ID;
					cur_prio_q <= '0;
				end
			end else if (set_prio) begin
				cur_prio_q <= prio_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-event payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind_t'(s_axis_tuser);
			tid_q    <= s_axis_tdata[3:0];
			prio_q   <= prio_clamped;
			wake_q   <= s_axis_tdata[72:10];
			old_id_q <= cur_id_q;
			woken_q  <= '0;
			status_q <= ST_OK;
		end else begin
			if (woken_inc) begin
				woken_q <= woken_q + CNTW'(1);
			end
			if (mark_full) begin
				status_q <= ST_FULL;
			end else if (mark_inval) begin
				status_q <= ST_INVAL;
			end
		end
		if (save_yield) begin
			yield_q <= '{id: ID_W'(cur_id_q), prio: cur_prio_q};
		end
		if (out_load) begin
			out_data_q <= OTW'({status_q, woken_q, cur_id_q != old_id_q, cur_prio_q, cur_id_q});
		end
	end

endmodule

/* sim/scheduler_checker.sv */
`timescale 1ns / 1ps

module scheduler_checker import pts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,
	input  logic [2:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	output int          errors,
	output int          pending
);

	localparam int NTASK = 16;
	localparam logic [4:0] IDLE_ID = 5'd16;

	// Members run from the highest bit down, so running_id lands in the lowest bits.
	typedef struct packed {
		status_t    st;
		logic [4:0] woken;
		logic       sw;
		logic [5:0] prio;
		logic [4:0] id;
	} sched_result_t;

	sched_result_t result_fifo[$];

	logic [7:0]  slice_len;
	logic [3:0]  rq_id[NTASK];
	logic [5:0]  rq_prio[NTASK];
	int          rq_cnt;
	logic [3:0]  sq_id[NTASK];
	logic [63:0] sq_wake[NTASK];
	logic [5:0]  sq_prio[NTASK];
	int          sq_cnt;
	logic [4:0]  cur_id;
	logic [5:0]  cur_prio;
	logic [63:0] now;
	logic [7:0]  slice_cnt;
	int          item_no;

	function automatic bit ready_push(logic [3:0] id, logic [5:0] prio);
		int pos;
		pos = 0;
		if (rq_cnt >= NTASK)
			return 0;
		while (pos < rq_cnt && rq_prio[pos] >= prio)
			pos++;
		for (int i = rq_cnt; i > pos; i--) begin
			rq_id[i] = rq_id[i-1];
			rq_prio[i] = rq_prio[i-1];
		end
		rq_id[pos] = id;
		rq_prio[pos] = prio;
		rq_cnt++;
		return 1;
	endfunction

	function automatic void run_head();
		if (rq_cnt == 0) begin
			cur_id = IDLE_ID;
			cur_prio = '0;
		end else begin
			cur_id = {1'b0, rq_id[0]};
			cur_prio = rq_prio[0];
			for (int i = 1; i < rq_cnt; i++) begin
				rq_id[i-1] = rq_id[i];
				rq_prio[i-1] = rq_prio[i];
			end
			rq_cnt--;
		end
		slice_cnt = '0;
	endfunction

	function automatic void give_up_cpu();
		logic [4:0] id;
		logic [5:0] prio;
		bit         ok;
		id = cur_id;
		prio = cur_prio;
		if (id == IDLE_ID) begin
			run_head();
			return;
		end
		if (rq_cnt > 0 && rq_prio[0] >= prio) begin
			run_head();
			ok = ready_push(id[3:0], prio);
		end
		slice_cnt = '0;
	endfunction

	function automatic sched_result_t schedule_event(kind_t kind, logic [3:0] tid,
			logic [5:0] prio, logic [62:0] wake);
		sched_result_t r;
		logic [4:0] prev;
		logic [4:0] woken;
		status_t    st;
		logic [7:0] len;
		bit         idle;
		int         n, pos;
		prev = cur_id;
		woken = '0;
		st = ST_OK;
		idle = (cur_id == IDLE_ID);
		case (kind)
			K_TICK: begin
				len = (slice_len == 0) ? 8'd1 : slice_len;
				now = now + 64'd1;
				n = 0;
				while (n < sq_cnt && sq_wake[n] <= now) begin
					if (ready_push(sq_id[n], sq_prio[n]))
						woken++;
					else
						st = ST_FULL;
					n++;
				end
				for (int i = n; i < sq_cnt; i++) begin
					sq_id[i-n] = sq_id[i];
					sq_wake[i-n] = sq_wake[i];
					sq_prio[i-n] = sq_prio[i];
				end
				sq_cnt -= n;
				if (slice_cnt < SLICE_MAX)
					slice_cnt++;
				if (slice_cnt >= len || (cur_id == IDLE_ID && rq_cnt > 0))
					give_up_cpu();
			end
			K_CREATE, K_UNBLOCK: begin
				if (!ready_push(tid, prio))
					st = ST_FULL;
				else if (kind == K_CREATE && cur_prio < prio)
					give_up_cpu();
			end
			K_YIELD: give_up_cpu();
			K_BLOCK, K_EXIT: begin
				if (idle)
					st = ST_INVAL;
				else
					run_head();
			end
			K_SLEEP: begin
				if (idle) begin
					st = ST_INVAL;
				end else if (sq_cnt >= NTASK) begin
					st = ST_FULL;
				end else begin
					pos = 0;
					while (pos < sq_cnt && sq_wake[pos] <= {1'b0, wake})
						pos++;
					for (int i = sq_cnt; i > pos; i--) begin
						sq_id[i] = sq_id[i-1];
						sq_wake[i] = sq_wake[i-1];
						sq_prio[i] = sq_prio[i-1];
					end
					sq_id[pos] = cur_id[3:0];
					sq_wake[pos] = {1'b0, wake};
					sq_prio[pos] = cur_prio;
					sq_cnt++;
					run_head();
				end
			end
			default: begin
				if (idle) begin
					st = ST_INVAL;
				end else begin
					cur_prio = prio;
					if (rq_cnt > 0 && rq_prio[0] > cur_prio)
						give_up_cpu();
				end
			end
		endcase
		r.id = cur_id;
		r.prio = cur_prio;
		r.sw = (cur_id != prev);
		r.woken = woken;
		r.st = st;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH result %0d %s: got %0d expected %0d", item_no, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		item_no = 0;
		slice_len = SLICE_RESET;
		rq_cnt = 0;
		sq_cnt = 0;
		cur_id = IDLE_ID;
		cur_prio = '0;
		now = '0;
		slice_cnt = '0;
	end

	always @(posedge clk) begin
		sched_result_t got, want;
		if (arst_n) begin
			// Results are retired before new events are predicted, so a stray result
			// can never be matched against an expectation created at the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				got = sched_result_t'(m_axis_tdata[18:0]);
				if (result_fifo.size() == 0) begin
					$display("MISMATCH unexpected result %0d", item_no);
					errors++;
				end else begin
					want = result_fifo.pop_front();
					if (got.id !== want.id)
						report_mismatch("running_id", got.id, want.id);
					if (got.prio !== want.prio)
						report_mismatch("running_priority", got.prio, want.prio);
					if (got.sw !== want.sw)
						report_mismatch("switched", got.sw, want.sw);
					if (got.woken !== want.woken)
						report_mismatch("woken_count", got.woken, want.woken);
					if (got.st !== want.st)
						report_mismatch("status", got.st, want.st);
				end
				item_no++;
			end
			if (cfg_valid && cfg_ready)
				slice_len = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				result_fifo.push_back(schedule_event(kind_t'(s_axis_tuser),
					s_axis_tdata[3:0], s_axis_tdata[9:4], s_axis_tdata[72:10]));
			pending = result_fifo.size();
		end
	end

endmodule

/* sim/priority_task_scheduler_with_sleep_queue_test.sv */
`timescale 1ns / 1ps

module priority_task_scheduler_with_sleep_queue_test;
	import pts_pkg::*;

	// The watchdog fires when no transaction of any channel completes for this many cycles.
	// The longest legal quiet stretch is the receiver hold-off.
	localparam int QUIET_LIMIT = 6000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 225;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;

	int errors;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;
	int hold_left;
	int quiet_cycles;
	logic [63:0] ticks_sent;

	priority_task_scheduler_with_sleep_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// The checker sees every transaction on all three channels and keeps the prediction.
	scheduler_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.errors(errors),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Receiver: random stalls at the rate of the current phase.  A hold-off request keeps
	// tready low for a long stretch so that the block backs up into its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog on channel activity.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("priority_task_scheduler_with_sleep_queue verification failed");
			$finish;
		end
	end

	// Offers one event and returns at the edge where its transaction completes.
	// tvalid is only lowered inside a gap, so it never gets two assignments in one step.
	task automatic send_event(kind_t kind, logic [3:0] tid, logic [5:0] prio,
			logic [62:0] wake);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {7'd0, wake, prio, tid};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (kind == K_TICK)
			ticks_sent++;
	endtask

	// Waits for the block to drain before anything that needs it idle. It first waits for a
	// clock edge so that the checker has counted the transaction that just completed.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_slice(logic [7:0] len);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= len;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly wake ticks a short way ahead of the current time so that sleepers keep
	// cycling back; a few are already due and a rare one is a full-width value.
	function automatic logic [62:0] pick_wake();
		int r;
		r = $urandom_range(0, 99);
		if (r < 1)
			return 63'({$urandom, $urandom});
		if (r < 6)
			return '0;
		return ticks_sent[62:0] + 63'($urandom_range(0, 12));
	endfunction

	task automatic random_event();
		int    r;
		kind_t kind;
		r = $urandom_range(0, 99);
		if (r < 30)
			kind = K_TICK;
		else if (r < 50)
			kind = K_CREATE;
		else if (r < 58)
			kind = K_UNBLOCK;
		else if (r < 66)
			kind = K_YIELD;
		else if (r < 72)
			kind = K_BLOCK;
		else if (r < 84)
			kind = K_SLEEP;
		else if (r < 92)
			kind = K_SETPRIO;
		else
			kind = K_EXIT;
		send_event(kind, 4'($urandom), 6'($urandom), pick_wake());
	endtask

	task automatic random_phase(int items);
		for (int i = 0; i < items; i++)
			random_event();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = K_TICK;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		ticks_sent = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed events: requests while idle runs, priority extremes, equal-priority
		// ordering, sleeps that are already due, and a wake tick at the top of the range.
		send_event(K_TICK, 4'd0, 6'd0, '0);
		send_event(K_BLOCK, 4'd0, 6'd0, '0);
		send_event(K_SLEEP, 4'd0, 6'd0, '0);
		send_event(K_SETPRIO, 4'd0, 6'd63, '0);
		send_event(K_EXIT, 4'd0, 6'd0, '0);
		send_event(K_YIELD, 4'd0, 6'd0, '0);
		send_event(K_CREATE, 4'd0, 6'd63, '0);
		send_event(K_CREATE, 4'd15, 6'd0, '0);
		send_event(K_UNBLOCK, 4'd5, 6'd63, '0);
		send_event(K_CREATE, 4'd9, 6'd63, '0);
		send_event(K_YIELD, 4'd0, 6'd0, '0);
		send_event(K_SETPRIO, 4'd0, 6'd0, '0);
		send_event(K_SLEEP, 4'd0, 6'd0, '0);
		send_event(K_TICK, 4'd0, 6'd0, '0);
		send_event(K_SLEEP, 4'd0, 6'd0, '1);
		send_event(K_TICK, 4'd0, 6'd0, '0);
		send_event(K_TICK, 4'd0, 6'd0, '0);
		send_event(K_TICK, 4'd0, 6'd0, '0);
		send_event(K_TICK, 4'd0, 6'd0, '0);
		send_event(K_BLOCK, 4'd0, 6'd0, '0);
		send_event(K_EXIT, 4'd0, 6'd0, '0);
		// Fill the ready queue past its depth so the full case is hit.
		for (int i = 0; i < 17; i++)
			send_event(K_UNBLOCK, 4'(i), 6'($urandom), '0);

		random_phase(PHASE_ITEMS);

		write_slice(8'd1);
		send_idle_pct = 68;
		random_phase(PHASE_ITEMS);

		write_slice(8'd255);
		send_idle_pct = 0;
		recv_stall_pct = 68;
		random_phase(PHASE_ITEMS);

		write_slice(8'd0);
		send_idle_pct = 12;
		recv_stall_pct = 12;
		random_phase(PHASE_ITEMS);

		// Back-pressure: the receiver holds off while events keep coming, then the
		// sender pauses until every outstanding result has been returned.
		write_slice(8'($urandom_range(1, 254)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		random_phase(PHASE_ITEMS / 2);
		drain();
		random_phase(PHASE_ITEMS / 2);

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("priority_task_scheduler_with_sleep_queue verification clean");
		else
			$display("priority_task_scheduler_with_sleep_queue verification failed");
		$finish;
	end

endmodule

/* files.f */
design/pts_pkg.sv
design/pts_rdy_cell.sv
design/pts_slp_cell.sv
design/priority_task_scheduler_with_sleep_queue.sv
sim/scheduler_checker.sv
sim/priority_task_scheduler_with_sleep_queue_test.sv
